// ----- rtl/rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, codes and the decay root table shared by the flap damping table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  route_index;
		logic [31:0] now_secs;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] penalty_now;
		logic        suppressed;
		logic        entry_present;
		logic [15:0] flaps;
	} out_item_t;

	// stored per route
	typedef struct packed {
		logic        valid;
		logic        damped;
		logic [15:0] penalty;
		logic [15:0] flaps;
		logic [31:0] last_time;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [15:0] penalty;
		logic [31:0] elapsed;
	} decay_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] penalty;
	} decay_rsp_t;

	localparam logic [1:0] OP_WITHDRAW = 2'd0;
	localparam logic [1:0] OP_UPDATE   = 2'd1;
	localparam logic [1:0] OP_REUSE    = 2'd2;
	localparam logic [1:0] OP_PEEK     = 2'd3;  // reports entry as stored

	localparam logic [1:0] ST_CONTINUE    = 2'd0;
	localparam logic [1:0] ST_DISCONTINUE = 2'd1;
	localparam logic [1:0] ST_DISABLED    = 2'd2;

	localparam logic [2:0] CFG_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_HL_SECS   = 3'd1;
	localparam logic [2:0] CFG_REUSE     = 3'd2;
	localparam logic [2:0] CFG_SUPPRESS  = 3'd3;
	localparam logic [2:0] CFG_CAP       = 3'd4;
	localparam logic [2:0] CFG_MAX_HOLD  = 3'd5;
	localparam logic [2:0] CFG_FLAP_PEN  = 3'd6;

	localparam int ROOT_ENTRIES = 13;
	typedef logic [ROOT_ENTRIES-1:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = val;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// R[j] ~ 2^-(2^-j) in Q0.32
	function automatic root_tab_t build_roots();
		root_tab_t t;
		logic [63:0] r;
		r    = 64'h8000_0000;
		t[0] = r[31:0];
		for (int j = 1; j < ROOT_ENTRIES; j++) begin
			r    = isqrt64(r << 32);
			t[j] = r[31:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = build_roots();

endpackage

`default_nettype wire

// ----- rtl/rfd_ram.sv -----
// ----------------------------------------------------------------------------
// rfd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/rfd_decay.sv -----
// ----------------------------------------------------------------------------
// rfd_decay
// Iterative penalty decay: restoring divide by the half life, fraction
// digits, root-table product and final scale on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfd_decay #(
	parameter int DECAY_FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rfd_pkg::decay_req_t req,
	input  wire logic [15:0]        hl_secs,
	input  wire logic [15:0]        max_hold,
	output rfd_pkg::decay_rsp_t     rsp
);

	import rfd_pkg::*;

	localparam int DFB = DECAY_FRAC_BITS;

	typedef enum logic [6:0] {
		D_IDLE  = 7'b0000001,
		D_DIV1  = 7'b0000010,
		D_DIV2  = 7'b0000100,
		D_MUL   = 7'b0001000,
		D_SHIFT = 7'b0010000,
		D_SCALE = 7'b0100000,
		D_DONE  = 7'b1000000
	} dstate_t;

	dstate_t        state_q;
	logic [3:0]     cnt_q;
	logic [15:0]    dvd_q;
	logic [15:0]    rem_q;
	logic [15:0]    quo_q;
	logic [DFB-1:0] k_q;
	logic [31:0]    acc_q;
	logic           acc_one_q;
	logic [16:0]    f16_q;
	logic [15:0]    pen_q;
	logic [15:0]    res_q;

	logic [15:0] hl;
	logic [16:0] rem_sh;
	logic [17:0] diff;
	logic        ge;
	logic [15:0] rem_nx;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] root;
	logic [3:0]  root_idx;

	assign hl = (hl_secs == 16'd0) ? 16'd1 : hl_secs;

	// shared subtractor for both divide phases
	always_comb begin
		rem_sh = (state_q == D_DIV1) ? {rem_q, dvd_q[15]} : {rem_q, 1'b0};
		diff   = {1'b0, rem_sh} - {2'b00, hl};
		ge     = !diff[17];
		rem_nx = ge ? diff[15:0] : rem_sh[15:0];
	end

	assign root_idx = 4'(DFB) - cnt_q;
	assign root     = ROOTS[root_idx];

	// shared multiplier
	always_comb begin
		if (state_q == D_SCALE) begin
			mul_a = {16'd0, pen_q};
			mul_b = {15'd0, f16_q};
		end else begin
			mul_a = acc_q;
			mul_b = root;
		end
		prod = mul_a * mul_b;
	end

	assign rsp.done    = (state_q == D_DONE);
	assign rsp.penalty = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						pen_q <= req.penalty;
						cnt_q <= 4'd0;
						if (req.elapsed >= {16'd0, max_hold}) begin
							res_q   <= 16'd0;
							state_q <= D_DONE;
						end else begin
							dvd_q   <= req.elapsed[15:0];
							rem_q   <= 16'd0;
							quo_q   <= 16'd0;
							state_q <= D_DIV1;
						end
					end
				end
				D_DIV1: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[14:0], ge};
					dvd_q <= {dvd_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						cnt_q <= 4'd0;
						// quotient known only after the last digit
						if ({quo_q[14:0], ge} >= 16'd17) begin
							res_q   <= 16'd0;
							state_q <= D_DONE;
						end else begin
							state_q <= D_DIV2;
						end
					end
				end
				D_DIV2: begin
					rem_q <= rem_nx;
					k_q   <= {k_q[DFB-2:0], ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(DFB - 1)) begin
						cnt_q     <= 4'd0;
						acc_q     <= 32'd0;
						acc_one_q <= 1'b1;
						state_q   <= D_MUL;
					end
				end
				D_MUL: begin
					if (k_q[0]) begin
						acc_one_q <= 1'b0;
						acc_q     <= acc_one_q ? root : prod[63:32];
					end
					k_q   <= k_q >> 1;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(DFB - 1)) begin
						cnt_q   <= 4'd0;
						state_q <= D_SHIFT;
					end
				end
				D_SHIFT: begin
					f16_q   <= (acc_one_q ? 17'h10000 : {1'b0, acc_q[31:16]}) >> quo_q[4:0];
					state_q <= D_SCALE;
				end
				D_SCALE: begin
					res_q   <= prod[31:16];
					state_q <= D_DONE;
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/route_flap_damping_table_unit.sv -----
// ----------------------------------------------------------------------------
// route_flap_damping_table_unit
// Per-route flap damping table with iterative penalty decay.
// ----------------------------------------------------------------------------
// Usage: one event (withdraw, update, reuse check or peek) is taken on the in
// channel per transfer; one result per event leaves on the out channel.
// Registers are written on the cfg channel, which is always ready; write them
// only while the block is idle.
// Steps: an event that needs the full decay raises out_valid after the table
// read, 16 divide digits, DECAY_FRAC_BITS fraction digits and as many root
// steps, shift, scale and hand-off. A decay cut short at max hold skips the
// divide, one cut at a quotient of 17 or more ends after the divide digits;
// other events go from the table read straight to the result.
// Flow: one event at a time; in_ready is low while an event is in progress
// and rises with out_valid.
// Reset: after arst_n is released the table is swept once, one entry a cycle,
// with in_ready low. Config registers take their defaults at reset.
// Stall: the result sits in an output register; a new event may be taken
// while it waits, but that event does not finish until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module route_flap_damping_table_unit #(
	parameter int ROUTES          = 1024,
	parameter int DECAY_FRAC_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rfd_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rfd_pkg::out_item_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	import rfd_pkg::*;

	localparam int AW = $clog2(ROUTES);
	localparam int IW = (AW > 10) ? AW : 10;
	localparam int EW = $bits(entry_t);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_LOOK   = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t      state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic        in_range_q;
	logic [1:0]  op_q;
	logic [31:0] now_q;
	logic [15:0] dpen_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        enable_q;
	logic [15:0] hl_secs_q;
	logic [15:0] reuse_q;
	logic [15:0] suppress_q;
	logic [15:0] cap_q;
	logic [15:0] max_hold_q;
	logic [15:0] flap_pen_q;

	logic [IW-1:0] idx_w;
	logic          in_fire;
	logic          rd_en;
	logic [EW-1:0] rd_raw;
	entry_t        ent;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_ent;
	decay_req_t    dreq;
	decay_rsp_t    drsp;
	logic          need_decay;

	logic          fin_we;
	entry_t        fin_ent;
	out_item_t     fin_out;
	logic [16:0]   sum;
	logic [15:0]   pen_w;
	logic          fin_go;

	assign idx_w     = IW'(in_data.route_index);
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign rd_en     = in_fire;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign ent       = entry_t'(rd_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			hl_secs_q   <= 16'd900;
			reuse_q     <= 16'd750;
			suppress_q  <= 16'd2000;
			cap_q       <= 16'd12000;
			max_hold_q  <= 16'd3600;
			flap_pen_q  <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLE:    enable_q    <= cfg_data[0];
				CFG_HL_SECS:   hl_secs_q   <= cfg_data;
				CFG_REUSE:     reuse_q     <= cfg_data;
				CFG_SUPPRESS:  suppress_q  <= cfg_data;
				CFG_CAP:       cap_q       <= cfg_data;
				CFG_MAX_HOLD:  max_hold_q  <= cfg_data;
				CFG_FLAP_PEN:  flap_pen_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rfd_ram #(
		.WIDTH(EW),
		.DEPTH(ROUTES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_ent)),
		.rd_en   (rd_en),
		.rd_addr (idx_w[AW-1:0]),
		.rd_data (rd_raw)
	);

	rfd_decay #(
		.DECAY_FRAC_BITS(DECAY_FRAC_BITS)
	) u_decay (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (dreq),
		.hl_secs   (hl_secs_q),
		.max_hold  (max_hold_q),
		.rsp       (drsp)
	);

	assign need_decay = in_range_q && enable_q && ent.valid && (op_q != OP_PEEK);

	always_comb begin
		dreq.start   = (state_q == S_LOOK) && need_decay;
		dreq.penalty = ent.penalty;
		dreq.elapsed = now_q - ent.last_time;
	end

	// result and write-back
	always_comb begin
		fin_we  = 1'b0;
		fin_ent = ent;
		fin_ent.last_time = now_q;
		fin_out.status        = ST_CONTINUE;
		fin_out.penalty_now   = ent.valid ? ent.penalty : 16'd0;
		fin_out.suppressed    = ent.damped;
		fin_out.entry_present = ent.valid;
		fin_out.flaps         = ent.valid ? ent.flaps : 16'd0;
		sum   = ent.valid ? ({1'b0, dpen_q} + {1'b0, flap_pen_q}) : {1'b0, flap_pen_q};
		pen_w = (sum > {1'b0, cap_q}) ? cap_q : sum[15:0];
		if (!in_range_q) begin
			fin_out.status        = enable_q ? ST_CONTINUE : ST_DISABLED;
			fin_out.penalty_now   = 16'd0;
			fin_out.suppressed    = 1'b0;
			fin_out.entry_present = 1'b0;
			fin_out.flaps         = 16'd0;
		end else if (!enable_q) begin
			fin_out.status = ST_DISABLED;
		end else if (op_q == OP_WITHDRAW) begin
			fin_we          = 1'b1;
			fin_ent.valid   = 1'b1;
			fin_ent.penalty = pen_w;
			fin_ent.flaps   = !ent.valid ? 16'd1 :
				(ent.flaps == 16'hFFFF) ? ent.flaps : ent.flaps + 16'd1;
			fin_ent.damped  = ent.damped || (pen_w >= suppress_q);
			fin_out.status  = ent.damped ? ST_DISCONTINUE : ST_CONTINUE;
		end else if (ent.valid && (op_q == OP_UPDATE)) begin
			fin_we          = 1'b1;
			fin_ent.penalty = dpen_q;
			if (!ent.damped && dpen_q < suppress_q) begin
				fin_out.status = ST_CONTINUE;
			end else if (ent.damped && dpen_q < reuse_q) begin
				fin_ent.damped = 1'b0;
				fin_out.status = ST_CONTINUE;
			end else begin
				fin_out.status = ST_DISCONTINUE;
			end
		end else if (ent.valid && (op_q == OP_REUSE)) begin
			fin_we          = 1'b1;
			fin_ent.penalty = dpen_q;
			if (dpen_q <= (reuse_q >> 1)) begin
				fin_ent.damped = 1'b0;
				fin_ent.valid  = 1'b0;
			end else if (dpen_q < reuse_q) begin
				fin_ent.damped = 1'b0;
			end
			fin_out.status = fin_ent.damped ? ST_DISCONTINUE : ST_CONTINUE;
		end
		if (fin_we) begin
			fin_out.penalty_now   = fin_ent.valid ? fin_ent.penalty : 16'd0;
			fin_out.suppressed    = fin_ent.damped;
			fin_out.entry_present = fin_ent.valid;
			fin_out.flaps         = fin_ent.valid ? fin_ent.flaps : 16'd0;
		end
	end

	assign fin_go = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_ent  = '0;
		end else begin
			wr_en   = fin_go && fin_we;
			wr_addr = addr_q;
			wr_ent  = fin_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q     <= idx_w[AW-1:0];
			in_range_q <= (32'(in_data.route_index) < 32'(ROUTES));
			op_q       <= in_data.operation;
			now_q      <= in_data.now_secs;
		end
		if (state_q == S_LOOK)
			dpen_q <= 16'd0;
		else if (state_q == S_WAIT && drsp.done)
			dpen_q <= drsp.penalty;
		if (fin_go)
			out_q <= fin_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ROUTES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= need_decay ? S_WAIT : S_FINISH;
				end
				S_WAIT: begin
					if (drsp.done)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fin_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for route_flap_damping_table_unit: directed and random
// withdraw/update/reuse/peek events across several register settings, random
// sender bursts and receiver stalls, results checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import rfd_pkg::*;

	localparam int LIMIT = 1000000;

	class damping_scoreboard;
		out_item_t   pending_q[$];
		int          errors;
		logic [63:0] roots[13];
		logic [15:0] regs[7];
		bit          valid[1024];
		bit          damped[1024];
		logic [15:0] pen[1024];
		logic [15:0] flaps[1024];
		logic [31:0] last[1024];

		function new();
			logic [63:0] v, res, b;
			errors = 0;
			regs[CFG_ENABLE] = 0;     regs[CFG_HL_SECS] = 900;
			regs[CFG_REUSE] = 750;    regs[CFG_SUPPRESS] = 2000;
			regs[CFG_CAP] = 12000;    regs[CFG_MAX_HOLD] = 3600;
			regs[CFG_FLAP_PEN] = 1000;
			for (int i = 0; i < 1024; i++) begin
				valid[i] = 0;
				damped[i] = 0;
			end
			roots[0] = 64'h8000_0000;
			for (int j = 1; j < 13; j++) begin
				// bitwise integer square root of roots[j-1] * 2^32
				v = roots[j-1] << 32;
				res = 0;
				b = 64'd1 << 62;
				while (b != 0) begin
					if (v >= res + b) begin
						v = v - (res + b);
						res = (res >> 1) + b;
					end else begin
						res = res >> 1;
					end
					b = b >> 2;
				end
				roots[j] = res;
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			regs[idx] = (idx == CFG_ENABLE) ? {15'd0, val[0]} : val;
		endfunction

		function logic [15:0] decayed(logic [15:0] p, logic [31:0] el);
			logic [31:0] hl, q, r, k, f16;
			logic [63:0] acc;
			hl = (regs[CFG_HL_SECS] == 0) ? 32'd1 : {16'd0, regs[CFG_HL_SECS]};
			if (el >= {16'd0, regs[CFG_MAX_HOLD]}) return 0;
			q = el / hl;
			r = el % hl;
			if (q >= 17) return 0;
			k = (r << 8) / hl;
			acc = 64'h1_0000_0000;
			for (int b = 0; b < 8; b++)
				if (k[b]) acc = (acc * roots[8-b]) >> 32;
			f16 = acc[47:16] >> q;
			acc = ({48'd0, p} * {32'd0, f16}) >> 16;
			return acc[15:0];
		endfunction

		function void note(in_item_t it);
			out_item_t   e;
			logic [31:0] np;
			int          i;
			logic [1:0]  st;
			i = it.route_index;
			st = ST_CONTINUE;
			if (regs[CFG_ENABLE][0] == 0) begin
				st = ST_DISABLED;
			end else if (it.operation == OP_WITHDRAW) begin
				if (!valid[i]) begin
					valid[i] = 1;
					np = regs[CFG_FLAP_PEN];
					flaps[i] = 1;
				end else begin
					np = decayed(pen[i], it.now_secs - last[i]) + regs[CFG_FLAP_PEN];
					if (flaps[i] != 16'hFFFF) flaps[i]++;
				end
				if (np > regs[CFG_CAP]) np = regs[CFG_CAP];
				pen[i] = np[15:0];
				if (damped[i]) st = ST_DISCONTINUE;
				else if (np >= regs[CFG_SUPPRESS]) damped[i] = 1;
				last[i] = it.now_secs;
			end else if (it.operation == OP_UPDATE && valid[i]) begin
				pen[i] = decayed(pen[i], it.now_secs - last[i]);
				if (!damped[i] && pen[i] < regs[CFG_SUPPRESS]) st = ST_CONTINUE;
				else if (damped[i] && pen[i] < regs[CFG_REUSE]) damped[i] = 0;
				else st = ST_DISCONTINUE;
				last[i] = it.now_secs;
			end else if (it.operation == OP_REUSE && valid[i]) begin
				pen[i] = decayed(pen[i], it.now_secs - last[i]);
				last[i] = it.now_secs;
				if (pen[i] <= regs[CFG_REUSE] / 2) begin
					damped[i] = 0;
					valid[i] = 0;
				end else if (pen[i] < regs[CFG_REUSE]) begin
					damped[i] = 0;
				end
				st = damped[i] ? ST_DISCONTINUE : ST_CONTINUE;
			end
			e.status = st;
			e.penalty_now = valid[i] ? pen[i] : 16'd0;
			e.flaps = valid[i] ? flaps[i] : 16'd0;
			e.entry_present = valid[i];
			e.suppressed = damped[i];
			pending_q.push_back(e);
		endfunction

		function void check(out_item_t got);
			out_item_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			e = pending_q.pop_front();
			if (got.status != e.status || got.penalty_now != e.penalty_now ||
			    got.suppressed != e.suppressed || got.entry_present != e.entry_present ||
			    got.flaps != e.flaps) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic      clk, arst_n;
	logic      in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t  in_data;
	out_item_t out_data;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	damping_scoreboard sb;
	int cycles;
	int burst_left;
	logic [31:0] clock_secs;

	route_flap_damping_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// receiver: stall mode is redrawn at random among four modes
	int stall_mode;
	always @(negedge clk) begin
		if (cycles % 150 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ((cycles / 7) % 3 != 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(out_data);

	task automatic send(logic [1:0] op, logic [9:0] route, logic [31:0] t);
		in_item_t it;
		it.operation = op;
		it.route_index = route;
		it.now_secs = t;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note(it);
		if (burst_left == 0) begin
			// gap between bursts; zero-length gap keeps valid high
			int gap;
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(logic en, logic [15:0] hl, logic [15:0] ru, logic [15:0] su,
	                     logic [15:0] cap, logic [15:0] mh, logic [15:0] fp);
		drain();
		write_reg(CFG_ENABLE, {15'd0, en});
		write_reg(CFG_HL_SECS, hl);
		write_reg(CFG_REUSE, ru);
		write_reg(CFG_SUPPRESS, su);
		write_reg(CFG_CAP, cap);
		write_reg(CFG_MAX_HOLD, mh);
		write_reg(CFG_FLAP_PEN, fp);
	endtask

	task automatic random_events(int n);
		int hl, sel;
		logic [1:0] op;
		logic [9:0] route;
		hl = (sb.regs[CFG_HL_SECS] == 0) ? 1 : sb.regs[CFG_HL_SECS];
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			op = sel < 45 ? OP_WITHDRAW : sel < 70 ? OP_UPDATE : sel < 95 ? OP_REUSE : OP_PEEK;
			// mostly a few hot routes so their history builds up
			route = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
			if ($urandom_range(0, 9) == 0) clock_secs = $urandom;
			else clock_secs += $urandom_range(0, 2 * hl);
			send(op, route, clock_secs);
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		clock_secs = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// disabled at reset
		send(OP_WITHDRAW, 10'd3, 32'd10);
		setup(1'b1, 16'd900, 16'd750, 16'd2000, 16'd12000, 16'd3600, 16'd1000);

		// directed: empty entry, build-up to suppression, release, freeing
		send(OP_UPDATE, 10'd5, 32'd0);
		send(OP_REUSE, 10'd5, 32'd0);
		send(OP_WITHDRAW, 10'd5, 32'd100);
		send(OP_WITHDRAW, 10'd5, 32'd100);   // newly suppressed, still continue
		send(OP_WITHDRAW, 10'd5, 32'd200);   // already damped -> discontinue
		send(OP_PEEK, 10'd5, 32'd5000);
		send(OP_UPDATE, 10'd5, 32'd300);
		send(OP_REUSE, 10'd5, 32'd1500);
		send(OP_UPDATE, 10'd5, 32'd3300);
		send(OP_WITHDRAW, 10'd5, 32'd100000); // past max hold
		send(OP_WITHDRAW, 10'd7, 32'd0);
		send(OP_REUSE, 10'd7, 32'd2000);      // frees entry
		send(OP_UPDATE, 10'd7, 32'd2001);
		send(OP_WITHDRAW, 10'd1023, 32'hFFFF_FFFF);
		send(OP_WITHDRAW, 10'd1023, 32'd5);   // elapsed wraps
		send(OP_WITHDRAW, 10'd1023, 32'd6);
		send(OP_PEEK, 10'd1023, 32'hFFFF_FFFF);
		send(OP_WITHDRAW, 10'd0, 32'd0);
		send(OP_PEEK, 10'd600, 32'd0);
		setup(1'b0, 16'd900, 16'd750, 16'd2000, 16'd12000, 16'd3600, 16'd1000);
		send(OP_WITHDRAW, 10'd5, 32'd200000);
		send(OP_REUSE, 10'd9, 32'd0);

		setup(1'b1, 16'd900, 16'd750, 16'd2000, 16'd12000, 16'd3600, 16'd1000);
		random_events(400);
		setup(1'b1, 16'd1, 16'd65535, 16'd1, 16'd65535, 16'd65535, 16'd65535);
		random_events(300);
		setup(1'b1, 16'd0, 16'd1, 16'd65535, 16'd1, 16'd1, 16'd0);
		random_events(250);
		setup(1'b1, 16'd65535, 16'd3000, 16'd5000, 16'd20000, 16'd65535, 16'd1500);
		random_events(400);
		setup(1'b1, 16'd60, 16'd750, 16'd2000, 16'd12000, 16'd600, 16'd1000);
		random_events(400);
		setup(1'b0, 16'd60, 16'd750, 16'd2000, 16'd12000, 16'd600, 16'd1000);
		random_events(100);
		setup(1'b1, 16'd300, 16'd1200, 16'd2500, 16'd9000, 16'd3000, 16'd800);
		random_events(150);

		drain();
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
